FILE: design/audio_level_meter_with_peak_hold_assert.svh
// ----------------------------------------------------------------------------
// audio level meter assertion macros
// clocked on clk_i, disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef AUDIO_LEVEL_METER_WITH_PEAK_HOLD_ASSERT_SVH
`define AUDIO_LEVEL_METER_WITH_PEAK_HOLD_ASSERT_SVH

// same-cycle implication
`define ALM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ALM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/alm_pkg.sv
// ----------------------------------------------------------------------------
// alm_pkg
// shared widths, constants, register indexes and control types
// ----------------------------------------------------------------------------
package alm_pkg;

  localparam int SAMPLE_W = 10;
  localparam int LVL_W    = 10;
  localparam int HGT_W    = 8;
  localparam int CFG_W    = 8;
  localparam int CFG_IDX_W = 3;

  localparam int HIST_DEPTH = 60;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);
  localparam int HIST_CW    = $clog2(HIST_DEPTH + 1);

  localparam int NUM_W  = HGT_W + LVL_W;
  localparam int DEN_W  = LVL_W;
  localparam int DIV_CW = $clog2(NUM_W + 1);

  localparam logic [LVL_W-1:0] MID_SCALE  = LVL_W'(512);
  localparam logic [DEN_W-1:0] SIMPLE_DEN = DEN_W'(255);
  localparam logic [HGT_W-1:0] HGT_MAX    = HGT_W'(255);
  localparam logic [NUM_W-1:0] SIMPLE_SAT = NUM_W'(255 * 255);

  localparam logic             MODE_RST   = 1'b0;
  localparam logic [CFG_W-1:0] DC_RST     = CFG_W'(0);
  localparam logic [CFG_W-1:0] NOISE_RST  = CFG_W'(10);
  localparam logic [CFG_W-1:0] TOP_RST    = CFG_W'(62);
  localparam logic [CFG_W-1:0] LED_RST    = CFG_W'(60);
  localparam logic [CFG_W-1:0] FALL_RST   = CFG_W'(10);
  localparam logic [LVL_W-1:0] SMOOTH_RST = LVL_W'(10);
  localparam logic [LVL_W-1:0] MINAVG_RST = LVL_W'(0);
  localparam logic [LVL_W-1:0] MAXAVG_RST = LVL_W'(512);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE,
    CFG_DC_OFFSET,
    CFG_NOISE_FLOOR,
    CFG_TOP_HEIGHT,
    CFG_LED_COUNT,
    CFG_FALL_PERIOD
  } cfg_idx_e;

  typedef struct packed {
    logic load;
    logic smooth;
    logic mul;
    logic div_start;
    logic finish;
  } alm_cmd_t;

  typedef struct packed {
    logic dyn;
    logic div_done;
    logic scan_done;
    logic out_free;
  } alm_sts_t;

endpackage

FILE: design/alm_if.sv
// ----------------------------------------------------------------------------
// alm_if
// valid/ready channels for samples and meter results
// ----------------------------------------------------------------------------
interface alm_in_if import alm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface alm_out_if import alm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [HGT_W-1:0] bar_height;
  logic [HGT_W-1:0] peak_position;
  logic             peak_shown;

  modport source (output valid, output bar_height, output peak_position, output peak_shown,
                  input ready);
  modport sink   (input valid, input bar_height, input peak_position, input peak_shown,
                  output ready);
endinterface

FILE: design/audio_level_meter_with_peak_hold.sv
// ----------------------------------------------------------------------------
// audio_level_meter_with_peak_hold
// auto-ranging audio bar meter with a falling peak dot
// ----------------------------------------------------------------------------
// One sample in, one result out. In dynamic mode the history min/max rescan
// of the 60-entry history reads one entry per cycle through the single memory
// read port, and the divider runs alongside it. Simple mode's fixed divide by
// 255 is a shift-and-add, so the divider stays idle. A new sample is taken once
// the previous one is done, even while its result still waits in the output
// register. History entries not yet written since reset count as zero through
// a fill count, so there is no clearing pass after reset.
// Configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i; the user
// must do so only while idle, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
`include "audio_level_meter_with_peak_hold_assert.svh"

module audio_level_meter_with_peak_hold import alm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  alm_in_if.sink               in_if,
  alm_out_if.source            out_if
);

  alm_cmd_t cmd;
  alm_sts_t sts;

  alm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  alm_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .sample_i        (in_if.sample),
    .out_ready_i     (out_if.ready),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_valid_o     (out_if.valid),
    .bar_height_o    (out_if.bar_height),
    .peak_position_o (out_if.peak_position),
    .peak_shown_o    (out_if.peak_shown)
  );

  `ALM_ASSERT_NEXT(a_busy_after_accept, in_if.valid && in_if.ready, !in_if.ready, "ready after accept")
  `ALM_ASSERT_IMPL(a_finish_out_free, cmd.finish, sts.out_free, "result overwritten")
  `ALM_ASSERT_NEXT(a_finish_shows_result, cmd.finish, out_if.valid, "result not presented")
  `ALM_ASSERT_IMPL(a_finish_after_scan, cmd.finish && sts.dyn, sts.scan_done && sts.div_done, "finish before scan")

endmodule

FILE: design/alm_div.sv
// ----------------------------------------------------------------------------
// alm_div
// iterative restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module alm_div import alm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [NUM_W-1:0] quot_o,
  output logic             done_o
);

  logic              busy_q;
  logic              done_q;
  logic [DIV_CW-1:0] cnt_q;
  logic [NUM_W-1:0]  acc_q;
  logic [DEN_W-1:0]  rem_q;
  logic [DEN_W-1:0]  den_q;

  logic [DEN_W:0] rem_sh;
  logic [DEN_W:0] rem_sub;
  logic           ge;

  assign rem_sh  = {rem_q, acc_q[NUM_W-1]};
  assign ge      = rem_sh >= {1'b0, den_q};
  assign rem_sub = rem_sh - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      acc_q  <= '0;
      rem_q  <= '0;
      den_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
      acc_q  <= num_i;
      rem_q  <= '0;
      den_q  <= den_i;
    end else if (busy_q) begin
      acc_q <= {acc_q[NUM_W-2:0], ge};
      rem_q <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      cnt_q <= cnt_q + DIV_CW'(1);
      if (cnt_q == DIV_CW'(NUM_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  assign quot_o = acc_q;
  assign done_o = done_q;

endmodule

FILE: design/alm_scan.sv
// ----------------------------------------------------------------------------
// alm_scan
// level history memory with min/max rescan, one entry per cycle
// ----------------------------------------------------------------------------
module alm_scan import alm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [LVL_W-1:0] wr_data_i,
  input  logic             start_i,
  output logic             done_o,
  output logic [LVL_W-1:0] lo_o,
  output logic [LVL_W-1:0] hi_o
);

  logic [LVL_W-1:0]   mem_q [HIST_DEPTH];
  logic [LVL_W-1:0]   rd_data_q;
  logic [HIST_AW-1:0] wr_idx_q;
  logic [HIST_CW-1:0] fill_q;
  logic [HIST_CW-1:0] rd_cnt_q;
  logic               busy_q;
  logic               done_q;
  logic               rd_vld_q;
  logic               rd_live_q;
  logic [LVL_W-1:0]   lo_q;
  logic [LVL_W-1:0]   hi_q;

  logic               rd_more;
  logic [HIST_AW-1:0] rd_addr;
  logic [LVL_W-1:0]   entry;

  assign rd_more = rd_cnt_q < HIST_CW'(HIST_DEPTH);
  assign rd_addr = rd_more ? rd_cnt_q[HIST_AW-1:0] : '0;
  // entries never written read as zero
  assign entry   = rd_live_q ? rd_data_q : '0;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_idx_q] <= wr_data_i;
    end
    rd_data_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q  <= '0;
      fill_q    <= '0;
      rd_cnt_q  <= '0;
      busy_q    <= 1'b0;
      done_q    <= 1'b0;
      rd_vld_q  <= 1'b0;
      rd_live_q <= 1'b0;
      lo_q      <= '0;
      hi_q      <= '0;
    end else begin
      if (wr_en_i) begin
        wr_idx_q <= (wr_idx_q == HIST_AW'(HIST_DEPTH - 1)) ? '0 : wr_idx_q + HIST_AW'(1);
        if (fill_q < HIST_CW'(HIST_DEPTH)) begin
          fill_q <= fill_q + HIST_CW'(1);
        end
      end
      if (start_i) begin
        busy_q   <= 1'b1;
        done_q   <= 1'b0;
        rd_cnt_q <= '0;
        rd_vld_q <= 1'b0;
        lo_q     <= '1;
        hi_q     <= '0;
      end else begin
        if (busy_q) begin
          if (rd_more) begin
            rd_vld_q  <= 1'b1;
            rd_live_q <= rd_cnt_q < fill_q;
            rd_cnt_q  <= rd_cnt_q + HIST_CW'(1);
          end else begin
            rd_vld_q <= 1'b0;
            busy_q   <= 1'b0;
            done_q   <= 1'b1;
          end
        end
        if (rd_vld_q) begin
          if (entry < lo_q) begin
            lo_q <= entry;
          end
          if (entry > hi_q) begin
            hi_q <= entry;
          end
        end
      end
    end
  end

  assign done_o = done_q;
  assign lo_o   = lo_q;
  assign hi_o   = hi_q;

endmodule

FILE: design/alm_dp.sv
// ----------------------------------------------------------------------------
// alm_dp
// meter datapath: config registers, level, scaling, peak dot, averages
// ----------------------------------------------------------------------------
module alm_dp import alm_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  input  logic [SAMPLE_W-1:0]  sample_i,
  input  logic                 out_ready_i,
  input  alm_cmd_t             cmd_i,
  output alm_sts_t             sts_o,
  output logic                 out_valid_o,
  output logic [HGT_W-1:0]     bar_height_o,
  output logic [HGT_W-1:0]     peak_position_o,
  output logic                 peak_shown_o
);

  // configuration
  logic             mode_q;
  logic [CFG_W-1:0] dc_q;
  logic [CFG_W-1:0] nf_q;
  logic [CFG_W-1:0] top_q;
  logic [CFG_W-1:0] led_q;
  logic [CFG_W-1:0] fall_q;

  // state
  logic [LVL_W-1:0] n_q;
  logic [LVL_W-1:0] sl_q;
  logic [HGT_W-1:0] peak_q;
  logic [HGT_W-1:0] fc_q;
  logic [LVL_W-1:0] min_avg_q;
  logic [LVL_W-1:0] max_avg_q;
  logic [NUM_W-1:0] prod_q;
  logic [DEN_W-1:0] den_q;
  logic             zero_q;
  logic             out_vld_q;
  logic [HGT_W-1:0] out_hgt_q;
  logic [HGT_W-1:0] out_peak_q;
  logic             out_shown_q;

  logic [LVL_W-1:0] centre;
  logic [LVL_W-1:0] mag;
  logic [LVL_W-1:0] n_d;
  logic [LVL_W+2:0] smooth_sum;
  logic [LVL_W-1:0] mul_a;
  logic             dyn_zero;
  logic [NUM_W-1:0] quot;
  logic             div_done;
  logic             scan_done;
  logic [LVL_W-1:0] scan_lo;
  logic [LVL_W-1:0] scan_hi;
  logic [NUM_W:0]   simple_sum;
  logic [HGT_W-1:0] hgt;
  logic [HGT_W-1:0] peak_new;
  logic [HGT_W-1:0] fc_inc;
  logic [LVL_W:0]   hi_adj;
  logic [16:0]      min_sum;
  logic [16:0]      max_sum;

  // front end: magnitude, and noise floor in dynamic mode
  assign centre = MID_SCALE + {{(LVL_W-CFG_W){1'b0}}, dc_q};
  assign mag    = (sample_i >= centre) ? (sample_i - centre) : (centre - sample_i);

  always_comb begin
    if (mode_q) begin
      n_d = mag;
    end else if (mag <= {{(LVL_W-CFG_W){1'b0}}, nf_q}) begin
      n_d = '0;
    end else begin
      n_d = mag - {{(LVL_W-CFG_W){1'b0}}, nf_q};
    end
  end

  // 7/8 old plus 1/8 new
  assign smooth_sum = ({sl_q, 3'b000} - {3'b000, sl_q}) + {3'b000, n_q};

  assign dyn_zero = (max_avg_q <= min_avg_q) || (sl_q <= min_avg_q);
  assign mul_a    = mode_q ? sl_q : (sl_q - min_avg_q);

  // divide by 255 as (x + x/256 + 1) / 256, exact below 255 * 255
  assign simple_sum = {1'b0, prod_q} + {{(HGT_W+1){1'b0}}, prod_q[NUM_W-1:HGT_W]}
                    + (NUM_W+1)'(1);

  alm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start && !mode_q),
    .num_i   (prod_q),
    .den_i   (den_q),
    .quot_o  (quot),
    .done_o  (div_done)
  );

  alm_scan u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cmd_i.smooth && !mode_q),
    .wr_data_i (n_q),
    .start_i   (cmd_i.smooth && !mode_q),
    .done_o    (scan_done),
    .lo_o      (scan_lo),
    .hi_o      (scan_hi)
  );

  // height, clipping and peak dot
  always_comb begin
    if (mode_q) begin
      hgt = (prod_q >= SIMPLE_SAT) ? HGT_MAX : simple_sum[2*HGT_W-1:HGT_W];
    end else if (zero_q) begin
      hgt = '0;
    end else begin
      hgt = (quot > NUM_W'(top_q)) ? top_q : quot[HGT_W-1:0];
    end
  end

  assign peak_new = (hgt > peak_q) ? hgt : peak_q;
  assign fc_inc   = fc_q + HGT_W'(1);

  // averages at 63/64 old plus 1/64 new, minimum spread of top height
  assign hi_adj  = ((scan_hi - scan_lo) < {{(LVL_W-CFG_W){1'b0}}, top_q})
                 ? ({1'b0, scan_lo} + {{(LVL_W-CFG_W+1){1'b0}}, top_q})
                 : {1'b0, scan_hi};
  assign min_sum = ({1'b0, min_avg_q, 6'b0} - {7'b0, min_avg_q}) + {7'b0, scan_lo};
  assign max_sum = ({1'b0, max_avg_q, 6'b0} - {7'b0, max_avg_q}) + {6'b0, hi_adj};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_RST;
      dc_q        <= DC_RST;
      nf_q        <= NOISE_RST;
      top_q       <= TOP_RST;
      led_q       <= LED_RST;
      fall_q      <= FALL_RST;
      n_q         <= '0;
      sl_q        <= SMOOTH_RST;
      peak_q      <= '0;
      fc_q        <= '0;
      min_avg_q   <= MINAVG_RST;
      max_avg_q   <= MAXAVG_RST;
      prod_q      <= '0;
      den_q       <= '0;
      zero_q      <= 1'b0;
      out_vld_q   <= 1'b0;
      out_hgt_q   <= '0;
      out_peak_q  <= '0;
      out_shown_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MODE:        mode_q <= cfg_data_i[0];
          CFG_DC_OFFSET:   dc_q   <= cfg_data_i;
          CFG_NOISE_FLOOR: nf_q   <= cfg_data_i;
          CFG_TOP_HEIGHT:  top_q  <= cfg_data_i;
          CFG_LED_COUNT:   led_q  <= cfg_data_i;
          CFG_FALL_PERIOD: fall_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.load) begin
        n_q <= n_d;
      end
      if (cmd_i.smooth) begin
        sl_q <= smooth_sum[LVL_W+2:3];
      end
      if (cmd_i.mul) begin
        prod_q <= NUM_W'(mul_a) * NUM_W'(top_q);
        den_q  <= max_avg_q - min_avg_q;
        zero_q <= dyn_zero;
      end
      if (cmd_i.finish) begin
        out_vld_q   <= 1'b1;
        out_hgt_q   <= hgt;
        out_peak_q  <= peak_new;
        out_shown_q <= (peak_new != '0) && (peak_new < led_q);
        if (fc_inc >= fall_q) begin
          peak_q <= (peak_new != '0) ? (peak_new - HGT_W'(1)) : '0;
          fc_q   <= '0;
        end else begin
          peak_q <= peak_new;
          fc_q   <= fc_inc;
        end
        if (!mode_q) begin
          min_avg_q <= min_sum[LVL_W+5:6];
          max_avg_q <= max_sum[LVL_W+5:6];
        end
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign sts_o.dyn       = !mode_q;
  assign sts_o.div_done  = div_done;
  assign sts_o.scan_done = scan_done;
  assign sts_o.out_free  = !out_vld_q || out_ready_i;

  assign out_valid_o     = out_vld_q;
  assign bar_height_o    = out_hgt_q;
  assign peak_position_o = out_peak_q;
  assign peak_shown_o    = out_shown_q;

endmodule

FILE: design/alm_ctrl.sv
// ----------------------------------------------------------------------------
// alm_ctrl
// per-transaction sequencer for the meter datapath
// ----------------------------------------------------------------------------
module alm_ctrl import alm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  alm_sts_t sts_i,
  output alm_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SMOOTH,
    S_MUL,
    S_DIV,
    S_WAIT,
    S_FINISH
  } state_e;

  state_e state_q;
  logic   in_ready_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      in_ready_q <= 1'b1;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q    <= S_SMOOTH;
            in_ready_q <= 1'b0;
          end
        end
        S_SMOOTH: state_q <= S_MUL;
        S_MUL:    state_q <= S_DIV;
        S_DIV:    state_q <= S_WAIT;
        S_WAIT: begin
          if (!sts_i.dyn || (sts_i.div_done && sts_i.scan_done)) begin
            state_q <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (sts_i.out_free) begin
            state_q    <= S_IDLE;
            in_ready_q <= 1'b1;
          end
        end
        default: begin
          state_q    <= S_IDLE;
          in_ready_q <= 1'b1;
        end
      endcase
    end
  end

  assign in_ready_o      = in_ready_q;
  assign cmd_o.load      = in_valid_i && in_ready_q;
  assign cmd_o.smooth    = (state_q == S_SMOOTH);
  assign cmd_o.mul       = (state_q == S_MUL);
  assign cmd_o.div_start = (state_q == S_DIV);
  assign cmd_o.finish    = (state_q == S_FINISH) && sts_i.out_free;

endmodule
